// ===== rtl/opsd_pkg.sv =====
// shared types and constants for the page segment deframer
`default_nettype none

package opsd_pkg;

   // lacing entries kept per page
   localparam int MAX_SEGMENTS = 255;
   localparam int SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);

   localparam int HEADER_BYTES  = 27;
   localparam int MAGIC_BYTES   = 4;
   localparam int HDR_POS_W     = 5;
   localparam int PAGE_LEN_W    = 16;
   localparam int ENTRY_W       = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // "OggS" read little-endian
   localparam logic [CSR_DATA_W-1:0] MAGIC_RESET = 32'h5367_674F;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_TABLE   = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_HEADER    = 2'd1,
      KIND_BAD_MAGIC = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      REG_EXPECTED_MAGIC = 1'd0
   } reg_index_type;

   typedef struct packed {
      kind_type                kind;
      logic [7:0]              payload_byte;
      logic [7:0]              segment_index;
      logic [7:0]              seg_length;
      logic                    last_of_segment;
      logic                    last_of_page;
      logic [PAGE_LEN_W-1:0]   page_length;
      logic [7:0]              segment_count;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/opsd_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module opsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/opsd_csr.sv =====
// configuration register file for the deframer
`default_nettype none

module opsd_csr
   import opsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      logic [CSR_DATA_W-1:0] expected_magic
);

   logic [CSR_DATA_W-1:0] magic_ff;
   logic [CSR_DATA_W-1:0] magic_in;
   reg_index_type         reg_sel;
   logic                  wr_access;

   assign reg_sel   = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_access = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      magic_in = magic_ff;
      if (wr_access && reg_sel == REG_EXPECTED_MAGIC) begin
         magic_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else begin
         magic_ff <= magic_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_EXPECTED_MAGIC: prdata = magic_ff;
         default:            prdata = '0;
      endcase
   end

   assign expected_magic = magic_ff;

endmodule

`default_nettype wire

// ===== rtl/opsd_core.sv =====
// header, lacing table and payload sequencer around the entry ram
`default_nettype none

module opsd_core
   import opsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            data_byte,
   input  wire logic [CSR_DATA_W-1:0] expected_magic,
   output      logic                  res_valid,
   output      result_type            res
);

   phase_type              phase_ff, phase_in;
   logic [HDR_POS_W-1:0]   hdr_pos_ff, hdr_pos_in;
   logic [23:0]            magic_ff, magic_in;
   logic [7:0]             tbl_size_ff, tbl_size_in;
   logic [7:0]             tbl_pos_ff, tbl_pos_in;
   logic [PAGE_LEN_W-1:0]  pay_total_ff, pay_total_in;
   logic [SEG_CNT_W-1:0]   nz_count_ff, nz_count_in;
   logic [SEG_CNT_W-1:0]   rd_entry_ff, rd_entry_in;
   logic [7:0]             byte_seg_ff, byte_seg_in;
   logic [ENTRY_W-1:0]     cur_ff, cur_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [ENTRY_W-1:0]     fwd_data_ff;

   logic                   wr_en;
   logic [SEG_IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   rd_en;
   logic [SEG_IDX_W-1:0]   rd_addr;
   logic [SEG_CNT_W:0]     rd_next;
   logic [ENTRY_W-1:0]     rd_data;
   logic [ENTRY_W-1:0]     nxt_entry;

   logic [7:0]             seg_len;
   logic                   seg_end;
   logic                   page_end;

   opsd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry after the current one, with same-cycle write bypass
   assign nxt_entry = fwd_valid_ff ? fwd_data_ff : rd_data;

   assign seg_len  = cur_ff[7:0];
   assign seg_end  = ({1'b0, byte_seg_ff} + 9'd1) >= {1'b0, seg_len};
   assign page_end = seg_end && (({1'b0, rd_entry_ff} + 1'b1) >= {1'b0, nz_count_ff});

   assign wr_addr = nz_count_ff[SEG_IDX_W-1:0];
   assign wr_data = {tbl_pos_ff, data_byte};
   assign wr_en   = take && phase_ff == PH_TABLE && data_byte != 8'd0
                    && nz_count_ff < SEG_CNT_W'(MAX_SEGMENTS);

   // prefetch the entry after the one in use
   assign rd_next      = {1'b0, rd_entry_in} + 1'b1;
   assign rd_en        = rd_next < (SEG_CNT_W + 1)'(MAX_SEGMENTS);
   assign rd_addr      = rd_next[SEG_IDX_W-1:0];
   assign fwd_valid_in = wr_en && rd_en && wr_addr == rd_addr;

   always_comb begin
      phase_in     = phase_ff;
      hdr_pos_in   = hdr_pos_ff;
      magic_in     = magic_ff;
      tbl_size_in  = tbl_size_ff;
      tbl_pos_in   = tbl_pos_ff;
      pay_total_in = pay_total_ff;
      nz_count_in  = nz_count_ff;
      rd_entry_in  = rd_entry_ff;
      byte_seg_in  = byte_seg_ff;
      cur_in       = cur_ff;
      res_valid    = 1'b0;
      res          = '0;
      res.kind     = KIND_PAYLOAD;

      if (take) begin
         case (phase_ff)
            PH_TABLE: begin
               pay_total_in = pay_total_ff + PAGE_LEN_W'(data_byte);
               nz_count_in  = nz_count_ff + SEG_CNT_W'(wr_en);
               if (wr_en && nz_count_ff == '0) begin
                  cur_in = wr_data;
               end
               tbl_pos_in = tbl_pos_ff + 8'd1;
               if (tbl_pos_in == tbl_size_ff) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_HEADER;
                  res.page_length   = PAGE_LEN_W'(HEADER_BYTES)
                                      + PAGE_LEN_W'(tbl_size_ff) + pay_total_in;
                  res.segment_count = tbl_size_ff;
                  if (nz_count_in == '0) begin
                     res.last_of_page = 1'b1;
                     phase_in         = PH_HEADER;
                     hdr_pos_in       = '0;
                     magic_in         = '0;
                  end else begin
                     phase_in    = PH_PAYLOAD;
                     rd_entry_in = '0;
                     byte_seg_in = '0;
                  end
               end
            end

            PH_PAYLOAD: begin
               res_valid           = 1'b1;
               res.kind            = KIND_PAYLOAD;
               res.payload_byte    = data_byte;
               res.segment_index   = cur_ff[15:8];
               res.seg_length      = seg_len;
               res.last_of_segment = seg_end;
               res.last_of_page    = page_end;
               if (page_end) begin
                  phase_in   = PH_HEADER;
                  hdr_pos_in = '0;
                  magic_in   = '0;
               end else if (seg_end) begin
                  rd_entry_in = rd_entry_ff + 1'b1;
                  byte_seg_in = '0;
                  cur_in      = nxt_entry;
               end else begin
                  byte_seg_in = byte_seg_ff + 8'd1;
               end
            end

            default: begin
               phase_in = PH_HEADER;
               if (hdr_pos_ff < HDR_POS_W'(MAGIC_BYTES - 1)) begin
                  magic_in   = magic_ff | (24'(data_byte) << {hdr_pos_ff[1:0], 3'b000});
                  hdr_pos_in = hdr_pos_ff + 1'b1;
               end else if (hdr_pos_ff == HDR_POS_W'(MAGIC_BYTES - 1)) begin
                  if ({data_byte, magic_ff} != expected_magic) begin
                     res_valid  = 1'b1;
                     res.kind   = KIND_BAD_MAGIC;
                     hdr_pos_in = '0;
                     magic_in   = '0;
                  end else begin
                     hdr_pos_in = hdr_pos_ff + 1'b1;
                  end
               end else if (hdr_pos_ff < HDR_POS_W'(HEADER_BYTES - 1)) begin
                  hdr_pos_in = hdr_pos_ff + 1'b1;
               end else begin
                  // segment count byte
                  tbl_size_in  = data_byte;
                  tbl_pos_in   = '0;
                  pay_total_in = '0;
                  nz_count_in  = '0;
                  rd_entry_in  = '0;
                  byte_seg_in  = '0;
                  hdr_pos_in   = '0;
                  if (data_byte == 8'd0) begin
                     res_valid         = 1'b1;
                     res.kind          = KIND_HEADER;
                     res.last_of_page  = 1'b1;
                     res.page_length   = PAGE_LEN_W'(HEADER_BYTES);
                     res.segment_count = 8'd0;
                     magic_in          = '0;
                  end else begin
                     phase_in = PH_TABLE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff   <= '0;
         magic_ff     <= '0;
         tbl_size_ff  <= '0;
         tbl_pos_ff   <= '0;
         pay_total_ff <= '0;
         nz_count_ff  <= '0;
         rd_entry_ff  <= '0;
         byte_seg_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         hdr_pos_ff   <= hdr_pos_in;
         magic_ff     <= magic_in;
         tbl_size_ff  <= tbl_size_in;
         tbl_pos_ff   <= tbl_pos_in;
         pay_total_ff <= pay_total_in;
         nz_count_ff  <= nz_count_in;
         rd_entry_ff  <= rd_entry_in;
         byte_seg_ff  <= byte_seg_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      fwd_data_ff <= wr_data;
   end

`ifndef SYNTHESIS
   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> phase_ff == PH_TABLE)
      else $error("entry write outside the lacing table");

   a_entry_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rd_entry_ff < nz_count_ff)
      else $error("segment entry beyond stored count");

   a_segment_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> seg_len != 8'd0)
      else $error("empty segment in payload");

   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> take)
      else $error("result without a byte transfer");

   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_TABLE && phase_in == PH_PAYLOAD
      |=> phase_ff == PH_PAYLOAD && byte_seg_ff == 8'd0 && rd_entry_ff == '0)
      else $error("payload did not start at the first segment");
`endif

endmodule

`default_nettype wire

// ===== rtl/ogg_page_segment_deframer.sv =====
// top level of the page segment deframer: config port, core and result register
`default_nettype none

// Takes one byte of a back-to-back page stream per cycle and returns at most
// one result per byte, in the cycle after the transfer, in a result register.
// A byte is taken in every cycle in which the result register is empty or
// being drained; the only stall comes from a stalled, full result register.
// The first four header bytes are compared (little-endian) with the
// expected_magic register; a mismatch gives a bad magic result and the
// header search restarts with the next byte. Header byte 26 is the segment
// count; after the lacing table a header result gives page length and
// segment count, then each payload byte comes out with its segment index,
// segment length and last-of-segment / last-of-page marks. Empty segments
// produce nothing. Nonzero lacing entries live in a 255-entry ram with one
// write and one read port; the entry after the one in use is prefetched,
// with a same-cycle write bypass, so segment changes never stall. The ram needs
// no clearing pass since every entry read in a page was written earlier in it.
// expected_magic must be written only while idle; this is not enforced.
module ogg_page_segment_deframer
   import opsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte stream
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [7:0]            req_data_byte,
   // results
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [1:0]            rsp_result_kind,
   output      logic [7:0]            rsp_payload_byte,
   output      logic [7:0]            rsp_segment_index,
   output      logic [7:0]            rsp_seg_length,
   output      logic                  rsp_last_of_segment,
   output      logic                  rsp_last_of_page,
   output      logic [PAGE_LEN_W-1:0] rsp_page_length,
   output      logic [7:0]            rsp_segment_count,
   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   logic [CSR_DATA_W-1:0] expected_magic;
   logic                  take;
   logic                  res_valid;
   result_type            res;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;

   opsd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .expected_magic (expected_magic)
   );

   // a byte moves whenever the result register can take what it makes
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   opsd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .data_byte      (req_data_byte),
      .expected_magic (expected_magic),
      .res_valid      (res_valid),
      .res            (res)
   );

   // result register: refilled in the cycle it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_ff.kind;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_segment_index   = rsp_ff.segment_index;
   assign rsp_seg_length      = rsp_ff.seg_length;
   assign rsp_last_of_segment = rsp_ff.last_of_segment;
   assign rsp_last_of_page    = rsp_ff.last_of_page;
   assign rsp_page_length     = rsp_ff.page_length;
   assign rsp_segment_count   = rsp_ff.segment_count;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the page segment deframer: page streams, magic register, stalls
`timescale 1ns / 1ps

module tb;
   import opsd_pkg::*;

   typedef logic [7:0] byte_queue_type[$];
   typedef int length_queue_type[$];

   localparam logic [CSR_ADDR_W-1:0] MAGIC_ADDR = CSR_ADDR_W'(4 * int'(REG_EXPECTED_MAGIC));
   localparam int RANDOM_ITEMS = 60;
   // covers the registered result plus margin
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // byte stream side
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'd0;

   // result side
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_result_kind;
   logic [7:0]            rsp_payload_byte;
   logic [7:0]            rsp_segment_index;
   logic [7:0]            rsp_seg_length;
   logic                  rsp_last_of_segment;
   logic                  rsp_last_of_page;
   logic [PAGE_LEN_W-1:0] rsp_page_length;
   logic [7:0]            rsp_segment_count;

   // register port
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // our own view of the deframer state
   phase_type   ph_state = PH_HEADER;
   logic [4:0]  hdr_pos = '0;
   logic [23:0] magic_lo = '0;
   logic [7:0]  tbl_size = '0;
   logic [7:0]  tbl_pos = '0;
   logic [15:0] pay_sum = '0;
   logic [15:0] lacing [MAX_SEGMENTS];
   logic [7:0]  nz_count = '0;
   logic [7:0]  rd_entry = '0;
   logic [7:0]  seg_byte = '0;
   logic [31:0] magic_reg = MAGIC_RESET;

   result_type upcoming_results[$];
   int mismatch_count = 0;
   int bytes_sent = 0;
   bit idle_on = 1'b1;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ogg_page_segment_deframer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_segment_index   (rsp_segment_index),
      .rsp_seg_length      (rsp_seg_length),
      .rsp_last_of_segment (rsp_last_of_segment),
      .rsp_last_of_page    (rsp_last_of_page),
      .rsp_page_length     (rsp_page_length),
      .rsp_segment_count   (rsp_segment_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic restart_hunt();
      ph_state = PH_HEADER;
      hdr_pos = '0;
      magic_lo = '0;
   endtask

   // advance the deframer view by one byte and queue the result it causes
   task automatic deframe_byte(input logic [7:0] b);
      result_type r;
      bit emit;
      logic [15:0] ent;
      bit seg_end;
      bit page_end;
      r = '0;
      emit = 1'b0;
      case (ph_state)
         PH_TABLE: begin
            pay_sum = pay_sum + b;
            if (b != 0 && nz_count < MAX_SEGMENTS) begin
               lacing[nz_count] = {tbl_pos, b};
               nz_count = nz_count + 1;
            end
            tbl_pos = tbl_pos + 1;
            if (tbl_pos == tbl_size) begin
               emit = 1'b1;
               r.kind = KIND_HEADER;
               r.page_length = 16'(HEADER_BYTES + tbl_size + pay_sum);
               r.segment_count = tbl_size;
               if (nz_count == 0) begin
                  // every segment empty: the header closes the page
                  r.last_of_page = 1'b1;
                  restart_hunt();
               end else begin
                  ph_state = PH_PAYLOAD;
                  rd_entry = '0;
                  seg_byte = '0;
               end
            end
         end
         PH_PAYLOAD: begin
            ent = (rd_entry < MAX_SEGMENTS) ? lacing[rd_entry] : '0;
            seg_end = (int'(seg_byte) + 1 >= int'(ent[7:0]));
            page_end = seg_end && (int'(rd_entry) + 1 >= int'(nz_count));
            emit = 1'b1;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.segment_index = ent[15:8];
            r.seg_length = ent[7:0];
            r.last_of_segment = seg_end;
            r.last_of_page = page_end;
            if (page_end)
               restart_hunt();
            else if (seg_end) begin
               rd_entry = rd_entry + 1;
               seg_byte = '0;
            end else
               seg_byte = seg_byte + 1;
         end
         default: begin
            ph_state = PH_HEADER;
            if (hdr_pos < 3) begin
               magic_lo = magic_lo | (24'(b) << (8 * hdr_pos));
               hdr_pos = hdr_pos + 1;
            end else if (hdr_pos == 3) begin
               if ({b, magic_lo} != magic_reg) begin
                  restart_hunt();
                  emit = 1'b1;
                  r.kind = KIND_BAD_MAGIC;
               end else
                  hdr_pos = hdr_pos + 1;
            end else if (hdr_pos < HEADER_BYTES - 1)
               hdr_pos = hdr_pos + 1;
            else begin
               // segment count byte
               tbl_size = b;
               tbl_pos = '0;
               pay_sum = '0;
               nz_count = '0;
               rd_entry = '0;
               seg_byte = '0;
               if (b == 0) begin
                  emit = 1'b1;
                  r.kind = KIND_HEADER;
                  r.page_length = 16'(HEADER_BYTES);
                  r.last_of_page = 1'b1;
                  restart_hunt();
               end else begin
                  ph_state = PH_TABLE;
                  hdr_pos = '0;
               end
            end
         end
      endcase
      if (emit)
         upcoming_results.push_back(r);
   endtask

   // one byte transfer, predicted once it is taken
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      deframe_byte(value);
      bytes_sent++;
   endtask

   // stop offering bytes until every queued result is out
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (upcoming_results.size() != 0);
   endtask

   task automatic write_magic(input logic [31:0] value);
      logic [31:0] readback;
      wait_for_idle();
      // bytes that made no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= MAGIC_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // straight into a read-back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      magic_reg = value;
      if (readback !== value)
         report_mismatch("expected_magic read-back", readback, value);
   endtask

   function automatic byte_queue_type build_page(input logic [31:0] magic,
                                                 input length_queue_type lens);
      byte_queue_type page;
      for (int i = 0; i < 4; i++)
         page.push_back(magic[8*i +: 8]);
      // version, flags, granule, serial, sequence, crc: never checked
      for (int i = 4; i < HEADER_BYTES - 1; i++)
         page.push_back(8'($urandom));
      page.push_back(8'(lens.size()));
      foreach (lens[i])
         page.push_back(8'(lens[i]));
      foreach (lens[i])
         repeat (lens[i]) page.push_back(8'($urandom));
      return page;
   endfunction

   // feed filler until a header starts on the next byte
   task automatic align_stream();
      logic [7:0] filler;
      while (!(ph_state == PH_HEADER && hdr_pos == 0)) begin
         // keep filler small where it becomes a length or a count
         if (ph_state == PH_TABLE)
            filler = $urandom_range(0, 8);
         else if (ph_state == PH_HEADER && hdr_pos == HEADER_BYTES - 1)
            filler = $urandom_range(0, 3);
         else
            filler = $urandom;
         send_byte(filler);
      end
   endtask

   task automatic send_page(input logic [31:0] magic, input length_queue_type lens);
      byte_queue_type page;
      align_stream();
      page = build_page(magic, lens);
      foreach (page[i])
         send_byte(page[i]);
   endtask

   function automatic length_queue_type random_lengths();
      length_queue_type lens;
      int count;
      int r;
      r = $urandom_range(0, 99);
      count = (r < 70) ? $urandom_range(0, 4) :
              (r < 95) ? $urandom_range(5, 16) : $urandom_range(17, 60);
      repeat (count) begin
         r = $urandom_range(0, 9);
         lens.push_back((r < 2) ? 0 : (r < 9) ? $urandom_range(1, 12) :
                        $urandom_range(13, 60));
      end
      return lens;
   endfunction

   // receiver: random stalls, a long hold-off on request, checks each transfer
   always @(posedge clock) begin : receiver
      int g;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               stall_left = g - 1;
               rsp_stall <= 1'b1;
            end else
               rsp_stall <= 1'b0;
         end
      end
   end

   task automatic check_result();
      result_type want;
      if (upcoming_results.size() == 0) begin
         report_mismatch("result with nothing expected, kind", rsp_result_kind, 0);
         return;
      end
      want = upcoming_results.pop_front();
      if (rsp_result_kind !== want.kind)
         report_mismatch("result_kind", rsp_result_kind, want.kind);
      if (rsp_payload_byte !== want.payload_byte)
         report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
      if (rsp_segment_index !== want.segment_index)
         report_mismatch("segment_index", rsp_segment_index, want.segment_index);
      if (rsp_seg_length !== want.seg_length)
         report_mismatch("seg_length", rsp_seg_length, want.seg_length);
      if (rsp_last_of_segment !== want.last_of_segment)
         report_mismatch("last_of_segment", rsp_last_of_segment, want.last_of_segment);
      if (rsp_last_of_page !== want.last_of_page)
         report_mismatch("last_of_page", rsp_last_of_page, want.last_of_page);
      if (rsp_page_length !== want.page_length)
         report_mismatch("page_length", rsp_page_length, want.page_length);
      if (rsp_segment_count !== want.segment_count)
         report_mismatch("segment_count", rsp_segment_count, want.segment_count);
   endtask

   // pages under the magic value left by reset, no register write yet
   task automatic test_reset_magic();
      send_page(MAGIC_RESET, '{3, 1, 0, 2});
      send_page(MAGIC_RESET, '{1});
   endtask

   // wrong capture pattern, then a good page to show the hunt recovers
   task automatic test_bad_magic();
      send_page(magic_reg ^ 32'h8000_0000, '{2});
      send_page(magic_reg ^ 32'h0000_0001, '{1});
      send_page(magic_reg, '{1, 2});
   endtask

   // a zero segment count closes the page right away
   task automatic test_empty_table();
      length_queue_type none;
      send_page(magic_reg, none);
      send_page(magic_reg, none);
   endtask

   // empty segments carry no bytes, alone or between full ones
   task automatic test_empty_segments();
      send_page(magic_reg, '{0, 0, 0});
      send_page(magic_reg, '{0, 5, 0, 0, 1, 0});
   endtask

   task automatic test_magic_register();
      write_magic(32'h0000_0000);
      send_page(magic_reg, '{2, 1});
      write_magic(32'hFFFF_FFFF);
      send_page(magic_reg, '{1});
      write_magic($urandom);
      send_page(magic_reg, '{3});
      write_magic(MAGIC_RESET);
   endtask

   // receiver holds off while bytes keep coming, then the sender drains
   task automatic test_stall_and_pause();
      hold_request = 300;
      send_page(magic_reg, '{30, 20});
      wait_for_idle();
      send_page(magic_reg, '{5});
   endtask

   // full table: last index after a long run of empty segments
   task automatic test_longest_page();
      length_queue_type lens;
      repeat (MAX_SEGMENTS - 1) lens.push_back(0);
      lens.push_back(1);
      idle_on = 1'b0;
      send_page(magic_reg, lens);
      idle_on = 1'b1;
   endtask

   // mostly well formed pages, some cut short, some noise, rare magic changes
   task automatic test_random_stream();
      int start;
      int pick;
      int cut;
      length_queue_type lens;
      byte_queue_type page;
      logic [31:0] magic;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 9) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 3)
            write_magic($urandom);
         else if (pick < 75) begin
            lens = random_lengths();
            magic = magic_reg;
            if ($urandom_range(0, 9) == 0)
               magic = magic ^ (32'd1 << $urandom_range(0, 31));
            send_page(magic, lens);
         end else if (pick < 88) begin
            // page cut off anywhere
            align_stream();
            lens = random_lengths();
            page = build_page(magic_reg, lens);
            cut = $urandom_range(1, page.size() - 1);
            for (int i = 0; i < cut; i++)
               send_byte(page[i]);
         end else begin
            align_stream();
            repeat ($urandom_range(1, 12)) send_byte($urandom);
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_magic();
      test_bad_magic();
      test_empty_table();
      test_empty_segments();
      test_magic_register();
      test_stall_and_pause();
      test_longest_page();
      test_random_stream();
      // drain what is still in flight
      req_valid <= 1'b0;
      waited = 0;
      while (upcoming_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (upcoming_results.size() != 0)
         report_mismatch("results never delivered, count", upcoming_results.size(), 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // hang guard, well above the slowest legal run
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== ogg_page_segment_deframer.f =====
rtl/opsd_pkg.sv
rtl/opsd_ram.sv
rtl/opsd_csr.sv
rtl/opsd_core.sv
rtl/ogg_page_segment_deframer.sv
tb/tb.sv
